// ===== design/kdat_pkg.sv =====
// ============================================================================
// Keyed decaying accumulator table package
// Shared types, codes and reset values for the accumulator table.
// ============================================================================
package kdat_pkg;

  localparam int unsigned ENTRIES_DEF = 64;

  localparam logic [15:0] RATE_RESET = 16'd3277;
  localparam logic [30:0] THRESH_RESET = 31'd66;
  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  // Action codes.
  localparam logic [1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [1:0] ACT_SENSE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Register indexes.
  localparam logic [0:0] REG_RATE = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic signed [31:0] price_tick;
    logic signed [31:0] amount;
    logic [15:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] level;
    logic [1:0] status;
    logic [6:0] removed_count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_FINISH,
    S_TICK_RD,
    S_TICK_MUL,
    S_TICK_WR
  } state_t;

endpackage

// ===== design/keyed_decaying_accumulator_table_top.sv =====
// ============================================================================
// Keyed decaying accumulator table
// Keyed Q16.16 accumulators with deposit, sense and decay tick.
// ============================================================================
// Deposit and sense walk the key store slot by slot (S_SEARCH reads, S_READ
// compares, S_FINISH gives the result). A tick reads, scales and writes back
// each slot in turn (S_TICK_RD, S_TICK_MUL, S_TICK_WR) through one multiplier;
// the unused action goes straight to S_FINISH. busy stays high until the
// result strobe, so the next word is taken at the result edge at the earliest;
// the receiver cannot stall. Synchronous reset clears the valid bits and
// restores the register defaults at once; no clearing pass is needed.
module keyed_decaying_accumulator_table_top #(
  parameter int unsigned ENTRIES = kdat_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kdat_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output kdat_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

  kdat_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] rate_r;
  logic [30:0] thresh_r;

  // Stores: valid bits in flip-flops, key and level in memories.
  logic [ENTRIES-1:0] valid_r;
  logic [31:0] key_mem [ENTRIES];
  logic signed [31:0] lvl_mem [ENTRIES];
  logic [31:0] key_rd_r;
  logic signed [31:0] lvl_rd_r;

  kdat_pkg::in_word_t item_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] rd_idx_r;
  logic found_r, found_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [24:0] factor_r;
  logic [55:0] prod_r;
  logic neg_r;
  logic [6:0] removed_r, removed_nxt;
  logic rd_en, mem_we;
  logic [IW-1:0] wr_idx;
  logic [31:0] wr_key;
  logic signed [31:0] wr_lvl;
  logic do_out;
  kdat_pkg::out_word_t res;
  logic valid_set, valid_clr;
  logic [IW-1:0] valid_idx;

  // Read address during a walk is the low bits of the slot counter.
  logic [IW-1:0] cur;
  assign cur = idx_r[IW-1:0];

  assign busy = (state_r != kdat_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Saturating deposit sum.
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  assign sum = {lvl_rd_r[31], lvl_rd_r} + {item_r.amount[31], item_r.amount};
  always_comb begin
    if (sum > 33'sd2147483647) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < -33'sd2147483648) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Decay: magnitude times factor, shifted, sign restored.
  logic [31:0] mag;
  logic [31:0] scaled_mag;
  logic signed [31:0] scaled;
  assign mag = lvl_rd_r[31] ? 32'(-lvl_rd_r) : lvl_rd_r;
  assign scaled_mag = prod_r[55:24];
  assign scaled = neg_r ? 32'(-scaled_mag) : scaled_mag;

  logic [31:0] rate_prod;
  assign rate_prod = 32'(rate_r) * 32'(item_r.elapsed);

  logic key_match;
  assign key_match = valid_r[rd_idx_r] && (key_rd_r == item_r.price_tick);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    hit_nxt = hit_r;
    free_ok_nxt = free_ok_r;
    free_nxt = free_r;
    removed_nxt = removed_r;
    rd_en = 1'b0;
    mem_we = 1'b0;
    wr_idx = cur;
    wr_key = item_r.price_tick;
    wr_lvl = sum_sat;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    valid_idx = cur;
    do_out = 1'b0;
    res = '0;
    unique case (state_r)
      kdat_pkg::S_IDLE: begin
        idx_nxt = '0;
        found_nxt = 1'b0;
        free_ok_nxt = 1'b0;
        removed_nxt = '0;
        if (start) begin
          if (in_word.action == kdat_pkg::ACT_TICK) begin
            state_nxt = kdat_pkg::S_TICK_RD;
          end else if (in_word.action == kdat_pkg::ACT_DEPOSIT ||
                       in_word.action == kdat_pkg::ACT_SENSE) begin
            state_nxt = kdat_pkg::S_SEARCH;
          end else begin
            state_nxt = kdat_pkg::S_FINISH;
          end
        end
      end
      kdat_pkg::S_SEARCH: begin
        // Issue the read of the current slot.
        rd_en = 1'b1;
        state_nxt = kdat_pkg::S_READ;
      end
      kdat_pkg::S_READ: begin
        // Compare the registered read; S_SEARCH fetches the next slot.
        if (!found_r && key_match) begin
          found_nxt = 1'b1;
          hit_nxt = rd_idx_r;
        end
        if (!free_ok_r && !valid_r[rd_idx_r]) begin
          free_ok_nxt = 1'b1;
          free_nxt = rd_idx_r;
        end
        if (idx_r == LAST) begin
          state_nxt = kdat_pkg::S_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = kdat_pkg::S_SEARCH;
        end
        // Fetch the hit slot's level on the final compare.
        if (idx_r == LAST) begin
          rd_en = 1'b1;
        end
      end
      kdat_pkg::S_FINISH: begin
        do_out = 1'b1;
        state_nxt = kdat_pkg::S_IDLE;
        if (item_r.action == kdat_pkg::ACT_DEPOSIT) begin
          if (found_r) begin
            mem_we = 1'b1;
            wr_idx = hit_r;
            wr_key = key_rd_r;
            wr_lvl = sum_sat;
            res.level = sum_sat;
            res.status = kdat_pkg::ST_HIT;
          end else if (free_ok_r) begin
            mem_we = 1'b1;
            wr_idx = free_r;
            wr_lvl = item_r.amount;
            valid_set = 1'b1;
            valid_idx = free_r;
            res.level = item_r.amount;
            res.status = kdat_pkg::ST_INSERTED;
          end else begin
            res.status = kdat_pkg::ST_FULL;
          end
        end else if (item_r.action == kdat_pkg::ACT_SENSE) begin
          if (found_r) begin
            res.level = lvl_rd_r;
          end else begin
            res.status = kdat_pkg::ST_MISS;
          end
        end else if (item_r.action == kdat_pkg::ACT_TICK) begin
          res.removed_count = removed_r;
        end
      end
      kdat_pkg::S_TICK_RD: begin
        rd_en = 1'b1;
        state_nxt = kdat_pkg::S_TICK_MUL;
      end
      kdat_pkg::S_TICK_MUL: begin
        state_nxt = kdat_pkg::S_TICK_WR;
      end
      kdat_pkg::S_TICK_WR: begin
        if (valid_r[cur]) begin
          mem_we = 1'b1;
          wr_key = key_rd_r;
          wr_lvl = scaled;
          if (scaled < $signed({1'b0, thresh_r})) begin
            valid_clr = 1'b1;
            if (removed_r != 7'd127) begin
              removed_nxt = removed_r + 1'b1;
            end
          end
        end
        if (idx_r == LAST) begin
          state_nxt = kdat_pkg::S_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = kdat_pkg::S_TICK_RD;
        end
      end
      default: state_nxt = kdat_pkg::S_IDLE;
    endcase
  end

  // Read address: the hit slot for the final level fetch, else the walk slot.
  logic [IW-1:0] rd_addr;
  assign rd_addr = (state_r == kdat_pkg::S_READ) ? (found_nxt ? hit_nxt : cur) : cur;

  // Memories: one write, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx] <= wr_key;
      lvl_mem[wr_idx] <= wr_lvl;
    end
    if (rd_en) begin
      key_rd_r <= key_mem[rd_addr];
      lvl_rd_r <= lvl_mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // Item capture, factor and shared multiplier.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_word;
    end
    if (state_r == kdat_pkg::S_TICK_RD && idx_r == '0) begin
      factor_r <= (rate_prod >= 32'(kdat_pkg::ONE_Q24)) ? 25'd0 :
                  25'(32'(kdat_pkg::ONE_Q24) - rate_prod);
    end
    if (state_r == kdat_pkg::S_TICK_MUL) begin
      prod_r <= 56'(mag) * 56'(factor_r);
      neg_r <= lvl_rd_r[31];
    end
    out_word <= res;
    hit_r <= hit_nxt;
    free_r <= free_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdat_pkg::S_IDLE;
      valid_r <= '0;
      rate_r <= kdat_pkg::RATE_RESET;
      thresh_r <= kdat_pkg::THRESH_RESET;
      idx_r <= '0;
      found_r <= 1'b0;
      free_ok_r <= 1'b0;
      removed_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      found_r <= found_nxt;
      free_ok_r <= free_ok_nxt;
      removed_r <= removed_nxt;
      out_strobe <= do_out;
      if (valid_set) begin
        valid_r[valid_idx] <= 1'b1;
      end
      if (valid_clr) begin
        valid_r[valid_idx] <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          kdat_pkg::REG_RATE: rate_r <= cfg_data[15:0];
          kdat_pkg::REG_THRESH: thresh_r <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/kdat_checker.sv =====
// ============================================================================
// Accumulator table port checker
// Port-level checks of the command handshake and result words.
// ============================================================================
module kdat_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input kdat_pkg::out_word_t out_word,
  input logic                out_strobe
);

  // An accepted word makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");

  // The block is idle while a result is shown.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy during result");

  // Strobes never come back to back.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("repeated result");

  // A miss or drop reports a zero level and no removals.
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_word.status == kdat_pkg::ST_MISS ||
                   out_word.status == kdat_pkg::ST_FULL)
    |-> out_word.level == 0 && out_word.removed_count == 0)
    else $error("miss carries data");

endmodule

bind keyed_decaying_accumulator_table_top kdat_checker u_kdat_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_word(out_word), .out_strobe(out_strobe)
);

// ===== tb/tb_top.sv =====
// ============================================================================
// Keyed decaying accumulator table testbench
// Drives deposits, senses and decay ticks into the table and checks every
// result word against a behavioural model or the directed row's result.
// ============================================================================
// A short table of directed words covers saturation, misses, the unused
// action and the decay extremes. Random traffic then follows, in several
// register settings, over a key pool larger than the table so that it fills.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = kdat_pkg::ENTRIES_DEF;
  localparam int unsigned POOL = 96;
  localparam int unsigned RANDOM_WORDS = 1020;
  localparam int unsigned DRAIN_CYCLES = 3 * SLOTS + 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  kdat_pkg::in_word_t in_word;
  logic out_strobe;
  kdat_pkg::out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  // Model state of the table and its registers.
  logic slot_used [SLOTS];
  logic [31:0] slot_tag [SLOTS];
  logic signed [31:0] slot_acc [SLOTS];
  logic [15:0] model_rate;
  logic [30:0] model_thresh;

  kdat_pkg::out_word_t level_book [$];
  logic [31:0] key_pool [POOL];
  int unsigned mismatches;
  int unsigned burst_left;

  // One directed row: the word to send and, where it is obvious, its result.
  typedef struct {
    kdat_pkg::in_word_t word;
    logic typed;
    kdat_pkg::out_word_t result;
  } row_t;

  row_t rows [$];

  keyed_decaying_accumulator_table_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one word to the model table and return the result it should give.
  function automatic kdat_pkg::out_word_t table_outcome(kdat_pkg::in_word_t w);
    kdat_pkg::out_word_t r;
    int hit;
    int free_slot;
    longint sum;
    logic [31:0] prod;
    logic [31:0] factor;
    longint mag;
    longint scaled;
    r = '0;
    hit = -1;
    free_slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_tag[i] == w.price_tick) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    case (w.action)
      kdat_pkg::ACT_DEPOSIT: begin
        if (hit >= 0) begin
          sum = longint'(slot_acc[hit]) + longint'(w.amount);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          slot_acc[hit] = sum[31:0];
          r.level = slot_acc[hit];
          r.status = kdat_pkg::ST_HIT;
        end else if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_tag[free_slot] = w.price_tick;
          slot_acc[free_slot] = w.amount;
          r.level = w.amount;
          r.status = kdat_pkg::ST_INSERTED;
        end else begin
          r.status = kdat_pkg::ST_FULL;
        end
      end
      kdat_pkg::ACT_SENSE: begin
        if (hit >= 0) r.level = slot_acc[hit];
        else r.status = kdat_pkg::ST_MISS;
      end
      kdat_pkg::ACT_TICK: begin
        prod = 32'(model_rate) * 32'(w.elapsed);
        factor = (prod >= 32'(kdat_pkg::ONE_Q24)) ? 32'd0 : 32'(kdat_pkg::ONE_Q24) - prod;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            mag = longint'(slot_acc[i]);
            if (mag < 0) mag = -mag;
            scaled = (mag * longint'(factor)) >>> 24;
            if (slot_acc[i] < 0) scaled = -scaled;
            slot_acc[i] = scaled[31:0];
            if (longint'(slot_acc[i]) < longint'(model_thresh)) begin
              slot_used[i] = 1'b0;
              if (r.removed_count < 7'd127) r.removed_count++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word and hold it until the table takes it.
  task automatic send_word(kdat_pkg::in_word_t w, logic typed,
                           kdat_pkg::out_word_t typed_result);
    kdat_pkg::out_word_t predicted;
    @(negedge clk);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predicted = table_outcome(w);
    level_book.push_back(typed ? typed_result : predicted);
  endtask

  // Random gaps between bursts of words.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Write one register while the table is idle.
  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == kdat_pkg::REG_RATE) model_rate = data[15:0];
    else model_thresh = data[30:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let every result arrive, then give the table time to settle.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (level_book.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A random word: mostly pool keys so that hits and a full table occur.
  function automatic kdat_pkg::in_word_t random_word();
    kdat_pkg::in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) w.action = kdat_pkg::ACT_DEPOSIT;
    else if (pick < 90) w.action = kdat_pkg::ACT_SENSE;
    else if (pick < 97) w.action = kdat_pkg::ACT_TICK;
    else w.action = kdat_pkg::ACT_UNUSED;
    w.price_tick = ($urandom_range(0, 9) == 0) ? $urandom()
                   : key_pool[$urandom_range(0, POOL - 1)];
    case ($urandom_range(0, 3))
      0: w.amount = $urandom();
      1: w.amount = $signed($urandom_range(0, 65535 * 16)) - 32'sd524280;
      default: w.amount = $urandom_range(0, 1 << 20);
    endcase
    w.elapsed = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 80));
    return w;
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (level_book.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: level %h status %0d removed %0d",
                   out_word.level, out_word.status, out_word.removed_count);
      end else begin
        kdat_pkg::out_word_t want;
        want = level_book.pop_front();
        if (out_word.level !== want.level || out_word.status !== want.status ||
            out_word.removed_count !== want.removed_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected level %h status %0d removed %0d, got %h %0d %0d",
                     want.level, want.status, want.removed_count,
                     out_word.level, out_word.status, out_word.removed_count);
        end
      end
    end
  end

  // Hard stop should the table hang.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence.
  initial begin
    row_t row;
    kdat_pkg::in_word_t w;
    logic [31:0] rates [4];
    logic [31:0] threshs [4];
    mismatches = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = kdat_pkg::REG_RATE;
    cfg_data = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_tag[i] = '0;
      slot_acc[i] = '0;
    end
    model_rate = kdat_pkg::RATE_RESET;
    model_thresh = kdat_pkg::THRESH_RESET;
    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h7fff_ffff;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, run with the reset register values.
    rows.push_back('{'{kdat_pkg::ACT_SENSE, 32'sd5, 32'sd0, 16'd0}, 1'b1,
                     '{32'sd0, kdat_pkg::ST_MISS, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'sd5, 32'h7fff_ffff, 16'd0}, 1'b1,
                     '{32'h7fff_ffff, kdat_pkg::ST_INSERTED, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'sd5, 32'sd1, 16'd0}, 1'b1,
                     '{32'h7fff_ffff, kdat_pkg::ST_HIT, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 16'hffff}, 1'b1,
                     '{32'h8000_0000, kdat_pkg::ST_INSERTED, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'h8000_0000, -32'sd1, 16'd0}, 1'b1,
                     '{32'h8000_0000, kdat_pkg::ST_HIT, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_SENSE, 32'sd5, 32'hffff_ffff, 16'hffff}, 1'b1,
                     '{32'h7fff_ffff, kdat_pkg::ST_HIT, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_UNUSED, 32'sd5, 32'sd7, 16'd9}, 1'b1,
                     '{32'sd0, kdat_pkg::ST_HIT, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'sd7, 32'sd100, 16'd0}, 1'b1,
                     '{32'sd100, kdat_pkg::ST_INSERTED, 7'd0}});
    // Zero elapsed keeps the positives; the negative entry is always freed.
    rows.push_back('{'{kdat_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'd0}, 1'b1,
                     '{32'sd0, kdat_pkg::ST_HIT, 7'd1}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'hffff_ffff, 32'sd65536, 16'd0}, 1'b0, '0});
    rows.push_back('{'{kdat_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'd256}, 1'b0, '0});
    rows.push_back('{'{kdat_pkg::ACT_SENSE, 32'hffff_ffff, 32'sd0, 16'd0}, 1'b0, '0});
    // A factor clamped at zero clears everything.
    rows.push_back('{'{kdat_pkg::ACT_TICK, 32'hffff_ffff, 32'h7fff_ffff, 16'hffff}, 1'b1,
                     '{32'sd0, kdat_pkg::ST_HIT, 7'd3}});
    rows.push_back('{'{kdat_pkg::ACT_SENSE, 32'sd5, 32'sd0, 16'd0}, 1'b1,
                     '{32'sd0, kdat_pkg::ST_MISS, 7'd0}});
    rows.push_back('{'{kdat_pkg::ACT_DEPOSIT, 32'sd9, 32'sd60, 16'd0}, 1'b0, '0});
    rows.push_back('{'{kdat_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'd1}, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_word(row.word, row.typed, row.result);
      pace_sender();
    end
    settle();

    // Register settings: zero, full scale, random, then the reset values.
    rates[0] = 32'h0;          threshs[0] = 32'h0;
    rates[1] = 32'hffff_ffff;  threshs[1] = 32'hffff_ffff;
    rates[2] = $urandom();     threshs[2] = $urandom_range(0, 1 << 18);
    rates[3] = 32'd3277;       threshs[3] = 32'h8000_0042;
    for (int p = 0; p < 4; p++) begin
      write_reg(kdat_pkg::REG_RATE, rates[p]);
      write_reg(kdat_pkg::REG_THRESH, threshs[p]);
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        w = random_word();
        send_word(w, 1'b0, '0);
        pace_sender();
      end
      settle();
    end

    if (mismatches == 0 && level_book.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
